// ----- src/fcefc_pkg.sv -----
// Shared constants and types for the fluid cell energy feasibility check.
// No dependencies.
package fcefc_pkg;

	localparam int VAL_W = 48;
	localparam int HALF_W = 24;
	localparam int IDX_W = 20;
	localparam int SUM_W = 98;
	localparam int DIV_W = 49;
	localparam int QCNT_W = 6;
	localparam int Q_STEPS = 48;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	localparam logic [1:0] FAIL_NONE = 2'd0;
	localparam logic [1:0] FAIL_DENS = 2'd1;
	localparam logic [1:0] FAIL_ELEC = 2'd2;
	localparam logic [1:0] FAIL_ION  = 2'd3;

	localparam logic CFG_ELEC = 1'b0;
	localparam logic CFG_ION  = 1'b1;

	typedef struct packed {
		logic load;
		logic sq_step;
		logic div_init;
		logic div_step;
		logic finish;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic dens_bad;
		logic sq_last;
		logic sat;
		logic div_done;
	} stat_t;

endpackage

// ----- src/fcefc_datapath.sv -----
// Holds no module; the datapath of the feasibility check is fcefc_dp.
// No dependencies.

// ----- src/fcefc_ctrl.sv -----
// Controller state machine: sequences load, squares, division and update.
// Depends on fcefc_pkg.
module fcefc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  logic last_cell_q,
	input  fcefc_pkg::stat_t stat,
	output fcefc_pkg::cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SQ   = 3'd1;
	localparam logic [2:0] S_DINI = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_UPD  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0] state_q;
	logic acc;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign acc = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		cmd.load = acc;
		cmd.sq_step = (state_q == S_SQ);
		cmd.div_init = (state_q == S_DINI);
		cmd.div_step = (state_q == S_DIV);
		cmd.finish = (state_q == S_UPD);
		cmd.clear = (state_q == S_OUT) && !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (acc) state_q <= S_SQ;
				S_SQ: begin
					if (stat.skip || stat.dens_bad) state_q <= S_UPD;
					else if (stat.sq_last) state_q <= S_DINI;
				end
				S_DINI: state_q <= stat.sat ? S_UPD : S_DIV;
				S_DIV: if (stat.div_done) state_q <= S_UPD;
				S_UPD: state_q <= last_cell_q ? S_OUT : S_IDLE;
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- src/fcefc_dp.sv -----
// Datapath: captured cell, square accumulator, shift-subtract divider,
// running minima and failure record. Depends on fcefc_pkg.
module fcefc_dp (
	input  logic clk,
	input  logic arst_n,
	input  fcefc_pkg::cmd_t cmd,
	output fcefc_pkg::stat_t stat,
	output logic last_cell_q,
	input  logic cfg_we,
	input  logic cfg_idx,
	input  logic [47:0] cfg_data,
	input  logic signed [47:0] density,
	input  logic signed [47:0] momentum_radial,
	input  logic signed [47:0] momentum_polar,
	input  logic signed [47:0] momentum_azimuth,
	input  logic signed [47:0] total_energy,
	input  logic signed [47:0] elec_energy,
	input  logic last_cell,
	output logic feasible,
	output logic [1:0] failure_code,
	output logic [19:0] failure_index,
	output logic signed [47:0] lowest_electron,
	output logic signed [47:0] lowest_ion
);
	localparam int W = fcefc_pkg::VAL_W;
	localparam int HW = fcefc_pkg::HALF_W;
	localparam int SW = fcefc_pkg::SUM_W;
	localparam int DW = fcefc_pkg::DIV_W;

	logic signed [W-1:0] elec_floor_q, ion_floor_q;
	logic signed [W-1:0] rho_q, tot_q, elec_q;
	logic [W-1:0] m_q [3];
	logic [1:0] m_idx_q, part_q;
	logic [SW-1:0] sum_q;
	logic [DW:0] rem_q;
	logic [W-1:0] quot_q;
	logic [fcefc_pkg::QCNT_W-1:0] qcnt_q;
	logic sat_q, last_q;
	logic signed [W-1:0] min_e_q, min_i_q;
	logic failed_q;
	logic [1:0] code_q;
	logic [fcefc_pkg::IDX_W-1:0] cnt_q, fidx_q;

	logic [W-1:0] sel_m, mag;
	logic [HW-1:0] mul_a, mul_b;
	logic [W-1:0] pp;
	logic [SW-1:0] term;
	logic [DW-1:0] dvs;
	logic [DW+1:0] shifted;
	logic [DW+1:0] diff;
	logic [W-1:0] kin;
	logic signed [W+1:0] ion_full;
	logic signed [W-1:0] ion_sat;
	logic [SW-W-1:0] hi_part;

	// square of each magnitude as three 24x24 partial products
	assign sel_m = m_q[m_idx_q];
	assign mag = sel_m[W-1] ? (~sel_m + 1'b1) : sel_m;
	assign mul_a = (part_q == 2'd2) ? mag[W-1:HW] : mag[HW-1:0];
	assign mul_b = (part_q == 2'd0) ? mag[HW-1:0] : mag[W-1:HW];
	assign pp = mul_a * mul_b;
	assign term = (part_q == 2'd0) ? SW'(pp) :
		(part_q == 2'd1) ? (SW'(pp) << (HW + 1)) : (SW'(pp) << W);
	assign dvs = {rho_q, 1'b0};
	assign hi_part = sum_q[SW-1:W];
	assign shifted = {rem_q, sum_q[qcnt_q - 1'b1]};
	assign diff = shifted - {2'b00, dvs};
	assign kin = (sat_q || quot_q[W-1]) ? fcefc_pkg::VAL_MAX : quot_q;
	assign ion_full = {{2{tot_q[W-1]}}, tot_q} - {2'b00, kin} - {{2{elec_q[W-1]}}, elec_q};
	assign ion_sat = (ion_full > 50'sh0_7FFF_FFFF_FFFF) ? fcefc_pkg::VAL_MAX :
		(ion_full < -50'sh0_8000_0000_0000) ? fcefc_pkg::VAL_MIN : ion_full[W-1:0];

	assign stat.skip = failed_q;
	assign stat.dens_bad = rho_q[W-1] || (rho_q == '0);
	assign stat.sq_last = (m_idx_q == 2'd2) && (part_q == 2'd2);
	assign stat.div_done = (qcnt_q == fcefc_pkg::QCNT_W'(1));
	assign stat.sat = (hi_part >= {1'b0, dvs});
	assign last_cell_q = last_q;

	assign feasible = !failed_q;
	assign failure_code = code_q;
	assign failure_index = fidx_q;
	assign lowest_electron = min_e_q;
	assign lowest_ion = min_i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elec_floor_q <= '0;
			ion_floor_q <= '0;
		end else if (cfg_we) begin
			if (cfg_idx == fcefc_pkg::CFG_ELEC) elec_floor_q <= cfg_data;
			else ion_floor_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rho_q <= density;
			tot_q <= total_energy;
			elec_q <= elec_energy;
			m_q[0] <= momentum_radial;
			m_q[1] <= momentum_polar;
			m_q[2] <= momentum_azimuth;
			last_q <= last_cell;
			m_idx_q <= '0;
			part_q <= '0;
			sum_q <= '0;
		end else if (cmd.sq_step) begin
			sum_q <= sum_q + term;
			if (part_q == 2'd2) begin
				part_q <= '0;
				m_idx_q <= m_idx_q + 2'd1;
			end else begin
				part_q <= part_q + 2'd1;
			end
		end
		if (cmd.div_init) begin
			rem_q <= {1'b0, hi_part[DW-1:0]};
			quot_q <= '0;
			qcnt_q <= fcefc_pkg::QCNT_W'(fcefc_pkg::Q_STEPS);
			sat_q <= stat.sat;
		end else if (cmd.div_step) begin
			if (!diff[DW+1]) begin
				rem_q <= diff[DW:0];
				quot_q <= {quot_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DW:0];
				quot_q <= {quot_q[W-2:0], 1'b0};
			end
			qcnt_q <= qcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			min_e_q <= fcefc_pkg::VAL_MAX;
			min_i_q <= fcefc_pkg::VAL_MAX;
			failed_q <= 1'b0;
			code_q <= fcefc_pkg::FAIL_NONE;
			fidx_q <= '0;
		end else if (cmd.clear) begin
			cnt_q <= '0;
			min_e_q <= fcefc_pkg::VAL_MAX;
			min_i_q <= fcefc_pkg::VAL_MAX;
			failed_q <= 1'b0;
			code_q <= fcefc_pkg::FAIL_NONE;
			fidx_q <= '0;
		end else if (cmd.finish && !failed_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (stat.dens_bad) begin
				failed_q <= 1'b1;
				code_q <= fcefc_pkg::FAIL_DENS;
				fidx_q <= cnt_q;
				min_e_q <= '0;
				min_i_q <= '0;
			end else begin
				if (elec_q < min_e_q) min_e_q <= elec_q;
				if (ion_sat < min_i_q) min_i_q <= ion_sat;
				if (elec_q < elec_floor_q) begin
					failed_q <= 1'b1;
					code_q <= fcefc_pkg::FAIL_ELEC;
					fidx_q <= cnt_q;
				end else if (ion_sat < ion_floor_q) begin
					failed_q <= 1'b1;
					code_q <= fcefc_pkg::FAIL_ION;
					fidx_q <= cnt_q;
				end
			end
		end
	end
endmodule

// ----- src/fluid_cell_energy_feasibility_check_core.sv -----
// Top level of the fluid cell energy feasibility check.
// Depends on fcefc_pkg, fcefc_ctrl and fcefc_dp.
//
// Cells enter on the input channel (in_valid/in_stall), one item per
// handshake; last_cell closes a pass. The summary of a pass leaves on the
// output channel (out_valid/out_stall) one item per pass.
// After a cell is taken in_stall stays high. In a failed pass or with a
// density that is not positive the cell goes from the first square step
// to the update; a cell whose kinetic term saturates at once takes 9
// partial-product steps on one 24x24 multiplier and a divider set-up, any
// other cell also 48 divider steps. The next cell can be taken in the cycle
// after the update, not before. For a closing cell the summary shows from
// the cycle after its update, and no cell is taken until it is accepted;
// while the receiver stalls the summary holds. Reset clears the floors to
// zero and starts a fresh pass. The user must write floors through
// cfg_we/cfg_index/cfg_data only while the block idles; it is not enforced.
module fluid_cell_energy_feasibility_check_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [47:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [47:0] density,
	input  logic signed [47:0] momentum_radial,
	input  logic signed [47:0] momentum_polar,
	input  logic signed [47:0] momentum_azimuth,
	input  logic signed [47:0] total_energy,
	input  logic signed [47:0] elec_energy,
	input  logic last_cell,
	output logic out_valid,
	input  logic out_stall,
	output logic feasible,
	output logic [1:0] failure_code,
	output logic [19:0] failure_index,
	output logic signed [47:0] lowest_electron,
	output logic signed [47:0] lowest_ion
);
	fcefc_pkg::cmd_t cmd;
	fcefc_pkg::stat_t stat;
	logic last_q;

	fcefc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.last_cell_q(last_q), .stat, .cmd
	);

	fcefc_dp u_dp (
		.clk, .arst_n, .cmd, .stat, .last_cell_q(last_q),
		.cfg_we, .cfg_idx(cfg_index[0]), .cfg_data,
		.density, .momentum_radial, .momentum_polar, .momentum_azimuth,
		.total_energy, .elec_energy, .last_cell,
		.feasible, .failure_code, .failure_index, .lowest_electron, .lowest_ion
	);
endmodule

// ----- tb/fluid_cell_energy_feasibility_check_core_test.sv -----
// Testbench for fluid_cell_energy_feasibility_check_core: streams passes of cells,
// predicts each pass summary in-line and checks it field by field.
// Depends on fcefc_pkg and the core RTL.
module fluid_cell_energy_feasibility_check_core_test;
	localparam logic signed [47:0] VAL_MAX = fcefc_pkg::VAL_MAX;
	localparam logic signed [47:0] VAL_MIN = fcefc_pkg::VAL_MIN;
	localparam logic [1:0] FAIL_NONE = fcefc_pkg::FAIL_NONE;
	localparam logic [1:0] FAIL_DENS = fcefc_pkg::FAIL_DENS;
	localparam logic [1:0] FAIL_ELEC = fcefc_pkg::FAIL_ELEC;
	localparam logic [1:0] FAIL_ION = fcefc_pkg::FAIL_ION;
	localparam logic CFG_ELEC = fcefc_pkg::CFG_ELEC;
	localparam logic CFG_ION = fcefc_pkg::CFG_ION;

	typedef struct packed {
		logic        feasible;
		logic [1:0]  code;
		logic [19:0] index;
		logic signed [47:0] min_elec;
		logic signed [47:0] min_ion;
	} summary_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [0:0] cfg_index = CFG_ELEC;
	logic [47:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [47:0] density = '0, momentum_radial = '0, momentum_polar = '0;
	logic signed [47:0] momentum_azimuth = '0, total_energy = '0, elec_energy = '0;
	logic last_cell = 0;
	logic out_valid;
	logic out_stall = 0;
	logic feasible;
	logic [1:0] failure_code;
	logic [19:0] failure_index;
	logic signed [47:0] lowest_electron, lowest_ion;

	fluid_cell_energy_feasibility_check_core DUT (.*);

	always #5 clk = ~clk;

	// predictor state
	logic signed [47:0] floor_elec = '0, floor_ion = '0;
	logic [19:0] cell_count;
	logic signed [47:0] min_elec, min_ion;
	logic pass_failed;
	logic [1:0] fail_code;
	logic [19:0] fail_index;

	summary_t summaries_due[$];
	int mismatches = 0, summaries_seen = 0, cells_sent = 0, quiet_cycles = 0;
	int stall_pct = 28;

	function automatic void clear_pass();
		cell_count = '0;
		min_elec = VAL_MAX;
		min_ion = VAL_MAX;
		pass_failed = 0;
		fail_code = FAIL_NONE;
		fail_index = '0;
	endfunction

	function automatic void predict_cell(logic signed [47:0] rho, mr, mt, mp, tot, el,
			logic last);
		logic [127:0] sq_sum;
		logic [127:0] kin_wide;
		logic signed [47:0] kin, ion;
		logic signed [51:0] ion_wide;
		summary_t s;
		if (!pass_failed) begin
			if (rho <= 0) begin
				pass_failed = 1;
				fail_code = FAIL_DENS;
				fail_index = cell_count;
				min_elec = '0;
				min_ion = '0;
			end else begin
				sq_sum = 128'($signed(96'(mr)) * $signed(96'(mr)))
					+ 128'($signed(96'(mt)) * $signed(96'(mt)))
					+ 128'($signed(96'(mp)) * $signed(96'(mp)));
				kin_wide = sq_sum / (128'(rho) * 2);
				kin = (kin_wide > 128'(VAL_MAX)) ? VAL_MAX : kin_wide[47:0];
				ion_wide = 52'(tot) - 52'(kin) - 52'(el);
				if (ion_wide > 52'(VAL_MAX)) ion = VAL_MAX;
				else if (ion_wide < 52'(VAL_MIN)) ion = VAL_MIN;
				else ion = ion_wide[47:0];
				if (el < min_elec) min_elec = el;
				if (ion < min_ion) min_ion = ion;
				if (el < floor_elec) begin
					pass_failed = 1;
					fail_code = FAIL_ELEC;
					fail_index = cell_count;
				end else if (ion < floor_ion) begin
					pass_failed = 1;
					fail_code = FAIL_ION;
					fail_index = cell_count;
				end
			end
			cell_count = cell_count + 20'd1;
		end
		if (last) begin
			s.feasible = !pass_failed;
			s.code = fail_code;
			s.index = fail_index;
			s.min_elec = min_elec;
			s.min_ion = min_ion;
			summaries_due.push_back(s);
			clear_pass();
		end
	endfunction

	// valid stays high after acceptance until the next item or an idle
	task automatic send_cell(logic signed [47:0] rho, mr, mt, mp, tot, el, logic last);
		if ($urandom_range(99) < stall_pct) begin
			in_valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < stall_pct) @(posedge clk);
		end
		density <= rho;
		momentum_radial <= mr;
		momentum_polar <= mt;
		momentum_azimuth <= mp;
		total_energy <= tot;
		elec_energy <= el;
		last_cell <= last;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_cell(rho, mr, mt, mp, tot, el, last);
		cells_sent++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (summaries_due.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_floor(logic [0:0] idx, logic signed [47:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
		if (idx == CFG_ELEC) floor_elec = val;
		else floor_ion = val;
	endtask

	function automatic logic signed [47:0] rand_val();
		logic signed [47:0] v;
		v = 48'({$urandom, $urandom});
		case ($urandom_range(5))
			0: v = VAL_MAX;
			1: v = VAL_MIN;
			2: v = $signed(48'($urandom_range(4096))) - 2048;
			3: v = v >>> $urandom_range(40);
			default: ;
		endcase
		return v;
	endfunction

	// plausible cell: positive density, modest momenta, energy mostly sufficient
	task automatic send_good_cell(logic last);
		logic signed [47:0] rho, mr, mt, mp, el, tot;
		rho = 48'($urandom_range(1 << 26, 1)) << $urandom_range(8);
		mr = $signed(48'($urandom)) >>> $urandom_range(24, 8);
		mt = $signed(48'($urandom)) >>> $urandom_range(24, 8);
		mp = $signed(48'($urandom)) >>> $urandom_range(24, 8);
		el = $signed(48'($urandom_range(1 << 30)));
		if ($urandom_range(15) == 0) el = -el;
		tot = el + 48'({$urandom_range(1 << 14), $urandom});
		if ($urandom_range(15) == 0) tot = el - 48'($urandom_range(1 << 30));
		send_cell(rho, mr, mt, mp, tot, el, last);
	endtask

	task automatic test_directed();
		send_cell(48'sd1, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN, 0);
		send_cell(48'sd1 << 24, '0, '0, '0, 48'sd5 << 24, 48'sd1 << 24, 1);
		send_cell(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MIN, VAL_MAX, 1);
		send_cell(VAL_MAX, '0, '0, '0, VAL_MAX, VAL_MIN, 1);
		send_cell(48'sd1 << 24, '0, '0, '0, 48'sd3 << 24, 48'sd1 << 24, 0);
		send_cell('0, '0, '0, '0, '0, '0, 0);
		send_cell(48'sd1 << 24, '0, '0, '0, VAL_MIN, VAL_MIN, 1);
		send_cell(VAL_MIN, '1, '1, '1, '1, '1, 1);
		send_cell(-48'sd1, '0, '0, '0, '0, '0, 1);
		send_cell(48'sd1 << 24, '0, '0, '0, VAL_MAX, -48'sd1, 1);
		send_cell(48'sd1 << 24, 48'sd1 << 24, '0, '0, '0, '0, 0);
		send_cell(48'sd1 << 24, '0, '0, '0, VAL_MAX, '0, 1);
		send_cell(48'sd3, 48'sd5, -48'sd7, 48'sd9, 48'sd100, 48'sd2, 1);
		send_cell(48'sd1, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'sd1, 48'sd0, 48'sd0, 1);
		drain();
		write_floor(CFG_ELEC, VAL_MIN);
		write_floor(CFG_ION, VAL_MIN);
		send_cell(48'sd1 << 24, '0, '0, '0, VAL_MIN, VAL_MAX, 0);
		send_cell(48'sd2, VAL_MAX, '0, '0, VAL_MIN, VAL_MIN, 1);
		drain();
		write_floor(CFG_ELEC, VAL_MAX);
		write_floor(CFG_ION, VAL_MAX);
		send_cell(48'sd1 << 24, '0, '0, '0, VAL_MAX, VAL_MAX, 1);
		send_cell(48'sd1 << 24, '0, '0, '0, VAL_MAX, VAL_MAX - 1, 1);
		drain();
	endtask

	task automatic test_random_passes(int n_cells);
		int len, sent;
		sent = 0;
		while (sent < n_cells) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(9) < 8) send_good_cell(i == len - 1);
				else send_cell(rand_val(), rand_val(), rand_val(), rand_val(), rand_val(),
					rand_val(), i == len - 1);
			end
			sent += len;
			if ($urandom_range(40) == 0) drain();
		end
		drain();
	endtask

	task automatic test_floor_settings();
		logic signed [47:0] fl[4];
		fl = '{48'sd0, -48'sd1 << 24, 48'sd1 << 28, 48'sd1 << 20};
		for (int k = 0; k < 4; k++) begin
			write_floor(CFG_ELEC, fl[k]);
			write_floor(CFG_ION, fl[3 - k]);
			test_random_passes(250);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		summary_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				summaries_seen++;
				if (summaries_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected summary at %0t", $realtime);
				end else begin
					e = summaries_due.pop_front();
					if (e.feasible !== feasible || e.code !== failure_code ||
							e.index !== failure_index || e.min_elec !== lowest_electron ||
							e.min_ion !== lowest_ion) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: exp f=%0b c=%0d i=%0d e=%0d n=%0d",
								e.feasible, e.code, e.index, e.min_elec, e.min_ion);
							$display("          got f=%0b c=%0d i=%0d e=%0d n=%0d",
								feasible, failure_code, failure_index, lowest_electron,
								lowest_ion);
						end
					end
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		clear_pass();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random_passes(300);
		stall_pct = 0;
		test_random_passes(200);
		stall_pct = 28;
		test_floor_settings();
		write_floor(CFG_ELEC, '0);
		write_floor(CFG_ION, '0);
		test_random_passes(200);
		drain();
		$display("Sent %0d cells, checked %0d pass summaries across floor settings.",
			cells_sent, summaries_seen);
		if (mismatches == 0 && summaries_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
